FILE: rtl/iidl_pkg.sv
// Shared types and constants for the indexed insert/delete list.
// Used by iidl_ctrl, iidl_cell and indexed_insert_delete_list; depends on nothing.
`timescale 1ns / 1ps

package iidl_pkg;

  // Defaults for the top-level parameters.
  localparam int DEPTH_DEF      = 16;
  localparam int ELEM_WIDTH_DEF = 32;

  // Upper bounds of the parameter ranges.
  localparam int MAX_ELEM_WIDTH = 64;
  localparam int POS_W          = 8;   // holds any cell position up to 255
  localparam int CMP_W          = 9;   // holds DEPTH itself up to 256

  // Fixed port widths.
  localparam int MODE_W  = 3;
  localparam int INDEX_W = 4;
  localparam int VALUE_W = 32;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND   = 3'd0,
    MODE_REM_LAST = 3'd1,
    MODE_INSERT   = 3'd2,
    MODE_REM_AT   = 3'd3,
    MODE_READ     = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Command broadcast along the row of cells for one request.
  typedef struct packed {
    logic             load;        // cell at pos takes the new value
    logic             shift_up;    // cells above pos take their lower neighbor
    logic             shift_down;  // cells at and above pos take their upper neighbor
    logic             read;        // cell at pos drives its entry onto its tap
    logic [POS_W-1:0] pos;
  } cell_cmd_t;

endpackage

FILE: rtl/iidl_ctrl.sv
// Request decoder: turns mode, index and current length into a cell command,
// a status code and the next length. Depends on iidl_pkg.
`timescale 1ns / 1ps

module iidl_ctrl #(
  parameter int DEPTH = iidl_pkg::DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic [iidl_pkg::MODE_W-1:0]  mode,
  input  logic [iidl_pkg::INDEX_W-1:0] index,
  input  logic [CNT_W-1:0]             occ,
  output iidl_pkg::cell_cmd_t          cmd,
  output iidl_pkg::status_t            status,
  output logic [CNT_W-1:0]             occ_nxt
);

  localparam logic [iidl_pkg::CMP_W-1:0] DEPTH_C = iidl_pkg::CMP_W'(DEPTH);

  logic [iidl_pkg::CMP_W-1:0] idx_w;
  logic [iidl_pkg::CMP_W-1:0] occ_w;
  logic                       full;
  logic                       empty;

  assign idx_w = iidl_pkg::CMP_W'(index);
  assign occ_w = iidl_pkg::CMP_W'(occ);
  assign full  = (occ_w >= DEPTH_C);
  assign empty = (occ_w == '0);

  always_comb begin
    cmd     = '0;
    status  = iidl_pkg::ST_DONE;
    occ_nxt = occ;
    unique case (iidl_pkg::mode_t'(mode))
      iidl_pkg::MODE_APPEND: begin
        if (full) begin
          status = iidl_pkg::ST_FULL;
        end else begin
          cmd.load = 1'b1;
          cmd.pos  = iidl_pkg::POS_W'(occ_w);
          occ_nxt  = CNT_W'(occ_w + 1'b1);
        end
      end
      iidl_pkg::MODE_REM_LAST: begin
        if (empty) begin
          status = iidl_pkg::ST_RANGE;
        end else begin
          cmd.read = 1'b1;
          cmd.pos  = iidl_pkg::POS_W'(occ_w - 1'b1);
          occ_nxt  = CNT_W'(occ_w - 1'b1);
        end
      end
      iidl_pkg::MODE_INSERT: begin
        // Range is checked before fullness.
        if (idx_w > occ_w) begin
          status = iidl_pkg::ST_RANGE;
        end else if (full) begin
          status = iidl_pkg::ST_FULL;
        end else begin
          cmd.load     = 1'b1;
          cmd.shift_up = 1'b1;
          cmd.pos      = iidl_pkg::POS_W'(idx_w);
          occ_nxt      = CNT_W'(occ_w + 1'b1);
        end
      end
      iidl_pkg::MODE_REM_AT: begin
        if (idx_w >= occ_w) begin
          status = iidl_pkg::ST_RANGE;
        end else begin
          cmd.read       = 1'b1;
          cmd.shift_down = 1'b1;
          cmd.pos        = iidl_pkg::POS_W'(idx_w);
          occ_nxt        = CNT_W'(occ_w - 1'b1);
        end
      end
      iidl_pkg::MODE_READ: begin
        if (idx_w >= occ_w) begin
          status = iidl_pkg::ST_RANGE;
        end else begin
          cmd.read = 1'b1;
          cmd.pos  = iidl_pkg::POS_W'(idx_w);
        end
      end
      default: begin
        status = iidl_pkg::ST_RANGE;
      end
    endcase
  end

endmodule

FILE: rtl/iidl_cell.sv
// One storage cell of the list: holds an entry, trades it with its neighbors
// and drives a registered read tap. Depends on iidl_pkg.
`timescale 1ns / 1ps

module iidl_cell #(
  parameter int ELEM_WIDTH = iidl_pkg::ELEM_WIDTH_DEF,
  parameter int CELL_IDX   = 0
) (
  input  logic                  clk,
  input  logic                  en,
  input  iidl_pkg::cell_cmd_t   cmd,
  input  logic [ELEM_WIDTH-1:0] value,
  input  logic [ELEM_WIDTH-1:0] left,
  input  logic [ELEM_WIDTH-1:0] right,
  output logic [ELEM_WIDTH-1:0] data,
  output logic [ELEM_WIDTH-1:0] tap
);

  localparam logic [iidl_pkg::POS_W-1:0] MY_POS = iidl_pkg::POS_W'(CELL_IDX);

  logic [ELEM_WIDTH-1:0] data_r;
  logic [ELEM_WIDTH-1:0] data_nxt;
  logic [ELEM_WIDTH-1:0] tap_r;
  logic [ELEM_WIDTH-1:0] tap_nxt;
  logic                  hit;
  logic                  above;

  assign hit   = (cmd.pos == MY_POS);
  assign above = (MY_POS > cmd.pos);

  always_comb begin
    data_nxt = data_r;
    if (cmd.load && hit) begin
      data_nxt = value;
    end else if (cmd.shift_up && above) begin
      data_nxt = left;
    end else if (cmd.shift_down && (above || hit)) begin
      data_nxt = right;
    end
    // Tap sees the entry as it was before this request moved anything.
    tap_nxt = (cmd.read && hit) ? data_r : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
      tap_r  <= tap_nxt;
    end
  end

  assign data = data_r;
  assign tap  = tap_r;

endmodule

FILE: rtl/indexed_insert_delete_list.sv
// Top level of the indexed insert/delete list: row of cells, decoder and
// result register. Depends on iidl_pkg, iidl_ctrl and iidl_cell.
`timescale 1ns / 1ps

// Bounded ordered list of up to DEPTH entries of ELEM_WIDTH bits, built as a
// row of cells that all shift together. Each request (append, remove last,
// insert at index, remove at index, read at index) is decoded in the cycle
// it is accepted; at that edge every cell moves at once and the cell that is
// read latches its entry onto a tap. Once the result register is free, the
// taps are ORed into it and the result shows on out_valid. A new request is
// accepted in every cycle as long as results drain, so the sustained rate
// is one request per cycle; the only thing that holds off the input is a
// finished result that cannot leave the tap stage because the output
// register is still stalled. Full list, empty list and index out of range
// flag the request and leave the list as it is. Entries come up undefined
// after reset and need no clearing pass: only entries below the current
// length are ever returned.
module indexed_insert_delete_list #(
  parameter int DEPTH      = iidl_pkg::DEPTH_DEF,
  parameter int ELEM_WIDTH = iidl_pkg::ELEM_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [iidl_pkg::MODE_W-1:0]    in_mode,
  input  logic [iidl_pkg::INDEX_W-1:0]   in_index,
  input  logic [iidl_pkg::VALUE_W-1:0]   in_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [iidl_pkg::DATA_W-1:0]    out_data,
  output logic [1:0]                     out_status,
  output logic [iidl_pkg::COUNT_W-1:0]   out_count
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  // Request handshake.
  logic accept;

  // Decoder outputs.
  iidl_pkg::cell_cmd_t cmd;
  iidl_pkg::status_t   dec_status;
  logic [CNT_W-1:0]    occ_nxt;

  // List length.
  logic [CNT_W-1:0] occ_r;

  // Element value as stored, zero-extended or cut to ELEM_WIDTH.
  logic [iidl_pkg::MAX_ELEM_WIDTH-1:0] value_wide;
  logic [ELEM_WIDTH-1:0]               value_elem;

  // Row of cells.
  logic [ELEM_WIDTH-1:0] cell_data [DEPTH];
  logic [ELEM_WIDTH-1:0] cell_tap  [DEPTH];
  logic [ELEM_WIDTH-1:0] tap_or;
  logic [iidl_pkg::MAX_ELEM_WIDTH-1:0] tap_wide;

  // Tap stage: status and length of the request whose taps are loaded.
  logic              coll_r;
  logic              coll_go;
  iidl_pkg::status_t coll_status_r;
  logic [CNT_W-1:0]  coll_count_r;

  // Result register.
  logic                        out_valid_r;
  logic                        out_free;
  logic [iidl_pkg::DATA_W-1:0] out_data_r;
  iidl_pkg::status_t           out_status_r;
  logic [CNT_W-1:0]            out_count_r;

  // Handshake: the output register frees up when empty or taken this cycle;
  // the tap stage moves into it then, and a new request may overwrite taps
  // that still hold a result only then.
  assign out_free = !out_valid_r || !out_stall;
  assign coll_go  = coll_r && out_free;
  assign in_stall = coll_r && !coll_go;
  assign accept   = in_valid && !in_stall;

  iidl_ctrl #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .mode    (in_mode),
    .index   (in_index),
    .occ     (occ_r),
    .cmd     (cmd),
    .status  (dec_status),
    .occ_nxt (occ_nxt)
  );

  assign value_wide = iidl_pkg::MAX_ELEM_WIDTH'(in_value);
  assign value_elem = value_wide[ELEM_WIDTH-1:0];

  // Build the row; the ends see zero from the missing neighbor, which only
  // ever lands in a slot at or beyond the list length.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ELEM_WIDTH-1:0] left_in;
    logic [ELEM_WIDTH-1:0] right_in;

    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end

    iidl_cell #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .CELL_IDX   (i)
    ) u_cell (
      .clk   (clk),
      .en    (accept),
      .cmd   (cmd),
      .value (value_elem),
      .left  (left_in),
      .right (right_in),
      .data  (cell_data[i]),
      .tap   (cell_tap[i])
    );
  end

  // At most one tap is nonzero; no read leaves them all zero, which is the
  // data returned for append, insert and flagged requests.
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tap_or = tap_or | cell_tap[i];
    end
  end

  assign tap_wide = iidl_pkg::MAX_ELEM_WIDTH'(tap_or);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      coll_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        occ_r  <= occ_nxt;
        coll_r <= 1'b1;
      end else if (coll_go) begin
        coll_r <= 1'b0;
      end

      if (coll_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: hold while stalled, advance when the next stage is free.
  always_ff @(posedge clk) begin
    if (accept) begin
      coll_status_r <= dec_status;
      coll_count_r  <= occ_nxt;
    end
    if (coll_go) begin
      out_data_r   <= tap_wide[iidl_pkg::DATA_W-1:0];
      out_status_r <= coll_status_r;
      out_count_r  <= coll_count_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;
  assign out_count  = iidl_pkg::COUNT_W'(out_count_r);

  // Length never exceeds the number of cells.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(DEPTH))
    else $error("list length beyond DEPTH");

  // A flagged request leaves the length as it was.
  a_flag_keeps_len: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (dec_status != iidl_pkg::ST_DONE) |=> occ_r == $past(occ_r))
    else $error("flagged request changed the length");

  // A stored element grows the list by exactly one.
  a_load_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && cmd.load |=> occ_r == CNT_W'($past(occ_r) + 1'b1))
    else $error("load did not grow the list by one");

  // Every accepted request reaches the output register through the tap stage
  // when the output is not stalled.
  a_tap_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept ##1 !out_stall |=> out_valid_r)
    else $error("result lost between tap stage and output");

endmodule
